// ===== design/vector_distance_accumulator_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef VECTOR_DISTANCE_ACCUMULATOR_CORE_DEFINES_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_CORE_DEFINES_SVH

// Implication that must hold at every clock edge outside reset.
`define VDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define VDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== design/vda_pkg.sv =====
package vda_pkg;

   localparam int unsigned ELEM_BITS_DEFAULT = 16;
   localparam int unsigned ACC_BITS          = 32;
   localparam int unsigned MODE_BITS         = 4;
   localparam int unsigned QUEUE_DEPTH       = 4;

   typedef enum logic [3:0] {
      MODE_LINF  = 4'd0,
      MODE_L2    = 4'd1,
      MODE_L1    = 4'd2,
      MODE_L0    = 4'd3,
      MODE_CHI2  = 4'd4,
      MODE_HELL  = 4'd5,
      MODE_KL2   = 4'd6,
      MODE_KL1   = 4'd7,
      MODE_KCHI2 = 4'd8,
      MODE_KHELL = 4'd9,
      MODE_MIN   = 4'd10
   } mode_type;

   // Operation class chosen by the front end.
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_MAX  = 3'd1,
      OP_ADD  = 3'd2,
      OP_DIV  = 3'd3,
      OP_SQRT = 3'd4
   } op_type;

   // Sequencer states of the back end.
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_SQRT = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   // Classified work item passed from front to back.
   typedef struct packed {
      op_type             op;
      logic               last;
      logic               hell;     // Hellinger distance: add sum - 2*root
      logic [31:0]        value;    // term, or dividend, or radicand
      logic [31:0]        divisor;
      logic [31:0]        sum;
   } work_type;

endpackage

// ===== design/vda_front.sv =====
module vda_front #(
   parameter int unsigned ELEM_BITS = vda_pkg::ELEM_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [ELEM_BITS-1:0] elem_a,
   input  logic [ELEM_BITS-1:0] elem_b,
   input  logic                 last_elem,
   input  logic [3:0]           mode,
   output logic                 out_valid,
   input  logic                 out_stall,
   output vda_pkg::work_type    out_item
);

   logic                 valid_ff, valid_in;
   vda_pkg::work_type    item_ff, item_in;
   logic [31:0]          a32, b32, diff, prod, sum, lo;

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      a32  = 32'(elem_a);
      b32  = 32'(elem_b);
      diff = (a32 >= b32) ? a32 - b32 : b32 - a32;
      lo   = (a32 <= b32) ? a32 : b32;
      prod = a32 * b32;
      sum  = a32 + b32;
      item_in = '0;
      item_in.last = last_elem;
      item_in.sum  = sum;
      item_in.op   = vda_pkg::OP_NONE;
      case (mode)
         vda_pkg::MODE_LINF: begin
            item_in.op = vda_pkg::OP_MAX; item_in.value = diff;
         end
         vda_pkg::MODE_L2: begin
            item_in.op = vda_pkg::OP_ADD; item_in.value = diff * diff;
         end
         vda_pkg::MODE_L1: begin
            item_in.op = vda_pkg::OP_ADD; item_in.value = diff;
         end
         vda_pkg::MODE_L0: begin
            item_in.op = vda_pkg::OP_ADD; item_in.value = 32'(a32 != b32);
         end
         vda_pkg::MODE_CHI2: begin
            item_in.op = vda_pkg::OP_DIV; item_in.value = diff * diff;
            item_in.divisor = sum;
         end
         vda_pkg::MODE_HELL: begin
            item_in.op = vda_pkg::OP_SQRT; item_in.value = prod; item_in.hell = 1'b1;
         end
         vda_pkg::MODE_KL2: begin
            item_in.op = vda_pkg::OP_ADD; item_in.value = prod;
         end
         vda_pkg::MODE_KL1, vda_pkg::MODE_MIN: begin
            item_in.op = vda_pkg::OP_ADD; item_in.value = lo;
         end
         vda_pkg::MODE_KCHI2: begin
            item_in.op = vda_pkg::OP_DIV; item_in.value = prod;
            item_in.divisor = sum >> 1;
         end
         vda_pkg::MODE_KHELL: begin
            item_in.op = vda_pkg::OP_SQRT; item_in.value = prod;
         end
         default: item_in.op = vda_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (!in_stall) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (!in_stall && in_valid) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== design/vda_queue.sv =====
module vda_queue #(
   parameter int unsigned DEPTH = vda_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  vda_pkg::work_type in_item,
   output logic              out_valid,
   input  logic              out_stall,
   output vda_pkg::work_type out_item
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   vda_pkg::work_type         slot_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_BITS:0]         count_ff, count_in;
   logic                      push, pop;

   assign in_stall  = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      count_in = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; count_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; count_ff <= count_in;
      end
      if (push) slot_ff[wr_ff] <= in_item;
   end

endmodule

// ===== design/vda_back.sv =====
module vda_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  vda_pkg::work_type in_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_distance
);

   vda_pkg::state_type state_ff, state_in;
   vda_pkg::work_type  item_ff, item_in;
   logic [31:0] acc_ff, acc_in, rem_ff, rem_in, quo_ff, quo_in, root_ff, root_in;
   logic [31:0] bit_ff, bit_in, term;
   logic [5:0]  cnt_ff, cnt_in;
   logic        take, finish, ovalid_ff, ovalid_in;
   logic [31:0] odata_ff, odata_in;
   logic [32:0] trial;

   // A new transaction is taken only when idle and the output slot can absorb a result.
   assign take     = (state_ff == vda_pkg::ST_IDLE) && in_valid && !(ovalid_ff && rsp_stall);
   assign in_stall = !take;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vda_pkg::ST_IDLE:
            if (take) begin
               if (in_item.op == vda_pkg::OP_DIV && in_item.divisor != '0)
                  state_in = vda_pkg::ST_DIV;
               else if (in_item.op == vda_pkg::OP_SQRT)
                  state_in = vda_pkg::ST_SQRT;
            end
         vda_pkg::ST_DIV:  if (cnt_ff == 6'd31) state_in = vda_pkg::ST_DONE;
         vda_pkg::ST_SQRT: if (cnt_ff == 6'd15) state_in = vda_pkg::ST_DONE;
         vda_pkg::ST_DONE: if (!(ovalid_ff && rsp_stall)) state_in = vda_pkg::ST_IDLE;
         default: state_in = vda_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_in = item_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      trial   = '0;
      term    = '0;
      finish  = 1'b0;
      unique case (state_ff)
         vda_pkg::ST_IDLE: begin
            item_in = in_item;
            rem_in  = '0;
            quo_in  = in_item.value;
            root_in = '0;
            bit_in  = 32'h4000_0000;
            cnt_in  = '0;
            if (in_item.op == vda_pkg::OP_SQRT) rem_in = in_item.value;
            if (take) begin
               if (in_item.op == vda_pkg::OP_ADD) term = in_item.value;
               finish = !(in_item.op == vda_pkg::OP_SQRT ||
                          (in_item.op == vda_pkg::OP_DIV && in_item.divisor != '0));
            end
         end
         vda_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            trial = {rem_ff, quo_ff[31]} - {1'b0, item_ff.divisor};
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
         end
         vda_pkg::ST_SQRT: begin
            // Digit-by-digit square root, one result bit per cycle.
            if (rem_ff >= root_ff + bit_ff) begin
               rem_in  = rem_ff - (root_ff + bit_ff);
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
         end
         vda_pkg::ST_DONE: begin
            if (!(ovalid_ff && rsp_stall)) begin
               finish = 1'b1;
               if (item_ff.op == vda_pkg::OP_DIV) term = quo_ff;
               else if (item_ff.hell) term = item_ff.sum - {root_ff[30:0], 1'b0};
               else term = root_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      acc_in    = acc_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in  = odata_ff;
      if (finish) begin
         if (state_ff == vda_pkg::ST_IDLE && in_item.op == vda_pkg::OP_MAX)
            acc_in = (in_item.value > acc_ff) ? in_item.value : acc_ff;
         else
            acc_in = acc_ff + term;
         if ((state_ff == vda_pkg::ST_IDLE) ? in_item.last : item_ff.last) begin
            ovalid_in = 1'b1;
            odata_in  = acc_in;
            acc_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vda_pkg::ST_IDLE;
         acc_ff    <= '0;
         ovalid_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         ovalid_ff <= ovalid_in;
         cnt_ff    <= cnt_in;
      end
      item_ff  <= item_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      odata_ff <= odata_in;
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_distance = odata_ff;

endmodule

// ===== design/vector_distance_accumulator_core.sv =====
// Streaming distance and kernel accumulator for pairs of unsigned vector elements.
// A front stage classifies each pair by the mode register and forms its term; a
// four-entry queue feeds a back end that folds terms into a 32-bit accumulator
// and emits it on the pair marked last. Additive modes and L-infinity fold their
// term as the pair is taken. Chi2 and the chi2 kernel run a bit-serial divider,
// Hellinger modes a bit-serial square root; no new pair is taken until that result
// is folded in. A division by zero adds nothing. Write mode only when idle.
module vector_distance_accumulator_core #(
   parameter int unsigned ELEM_BITS = vda_pkg::ELEM_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ELEM_BITS-1:0] req_elem_a,
   input  logic [ELEM_BITS-1:0] req_elem_b,
   input  logic                 req_last_elem,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_distance,
   input  logic                 csr_write,
   input  logic [3:0]           csr_mode
);

   logic [3:0]        mode_ff;
   logic              f_valid, f_stall, q_valid, q_stall;
   vda_pkg::work_type f_item, q_item;

   always_ff @(posedge clock) begin
      if (reset)          mode_ff <= 4'(vda_pkg::MODE_L2);
      else if (csr_write) mode_ff <= csr_mode;
   end

   vda_front #(.ELEM_BITS(ELEM_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .elem_a(req_elem_a), .elem_b(req_elem_b), .last_elem(req_last_elem),
      .mode(mode_ff),
      .out_valid(f_valid), .out_stall(f_stall), .out_item(f_item)
   );

   vda_queue #(.DEPTH(vda_pkg::QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_item(f_item),
      .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item)
   );

   vda_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
      .rsp_valid, .rsp_stall, .rsp_distance
   );

endmodule

// ===== design/vda_checker.sv =====
`include "vector_distance_accumulator_core_defines.svh"

module vda_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_elem,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_distance
);

   // A result held under stall keeps its value.
   `VDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_distance))

   // A stalled transaction on the input side keeps its marker.
   `VDA_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_last_elem))

   // No result can appear in the cycle right after reset is released.
   `VDA_ASSERT_NEXT(a_rsp_after_idle, clock, reset, !rsp_valid && $past(reset), !rsp_valid)

   // Right after reset the input side is ready.
   `VDA_ASSERT_IMPL(a_reset_ready, clock, reset, $past(reset), !req_stall)

endmodule

bind vector_distance_accumulator_core vda_checker u_vda_checker (
   .clock, .reset, .req_valid, .req_stall, .req_last_elem,
   .rsp_valid, .rsp_stall, .rsp_distance
);

// ===== verif/vector_distance_accumulator_core_test.sv =====
module vector_distance_accumulator_core_test;

   typedef struct {
      logic [15:0] elem_a;
      logic [15:0] elem_b;
      logic        last_elem;
   } pair_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_elem_a;
   logic [15:0] req_elem_b;
   logic        req_last_elem;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_distance;
   logic        csr_write;
   logic [3:0]  csr_mode;

   pair_type    pending_pairs[$];
   logic [31:0] expected_distances[$];
   logic [3:0]  model_mode;
   logic [31:0] model_acc;
   int          mismatch_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;

   vector_distance_accumulator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_elem_a(req_elem_a), .req_elem_b(req_elem_b), .req_last_elem(req_last_elem),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance(rsp_distance),
      .csr_write(csr_write), .csr_mode(csr_mode)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] floor_root(logic [31:0] v);
      logic [31:0] root;
      logic [31:0] rem;
      logic [31:0] bit_val;
      root = 0;
      rem = v;
      bit_val = 32'h4000_0000;
      while (bit_val > rem) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (rem >= root + bit_val) begin
            rem = rem - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   // Folds one pair into the model accumulator; queues the distance on the last pair.
   task automatic accumulate_pair(pair_type p);
      logic [31:0] a, b, diff, lo, prod, sum, acc, mean;
      a = {16'd0, p.elem_a};
      b = {16'd0, p.elem_b};
      diff = (a >= b) ? a - b : b - a;
      lo = (a <= b) ? a : b;
      prod = a * b;
      sum = a + b;
      acc = model_acc;
      case (model_mode)
         vda_pkg::MODE_LINF: if (diff > acc) acc = diff;
         vda_pkg::MODE_L2: acc = acc + diff * diff;
         vda_pkg::MODE_L1: acc = acc + diff;
         vda_pkg::MODE_L0: acc = acc + ((a != b) ? 32'd1 : 32'd0);
         vda_pkg::MODE_CHI2: if (sum != 0) acc = acc + (diff * diff) / sum;
         vda_pkg::MODE_HELL: acc = acc + sum - 2 * floor_root(prod);
         vda_pkg::MODE_KL2: acc = acc + prod;
         vda_pkg::MODE_KL1, vda_pkg::MODE_MIN: acc = acc + lo;
         vda_pkg::MODE_KCHI2: begin
            mean = sum / 2;
            if (mean != 0) acc = acc + prod / mean;
         end
         vda_pkg::MODE_KHELL: acc = acc + floor_root(prod);
         default: ;
      endcase
      if (p.last_elem) begin
         expected_distances.push_back(acc);
         model_acc = 0;
      end else begin
         model_acc = acc;
      end
   endtask

   // Driver: valid is independent of stall, payload holds while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            pair_type p;
            p = pending_pairs.pop_front();
            accumulate_pair(p);
            req_valid <= 1'b1;
            req_elem_a <= p.elem_a;
            req_elem_b <= p.elem_b;
            req_last_elem <= p.last_elem;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: each transaction is compared against the oldest expected distance.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_distances.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected distance %h", rsp_distance);
         end else begin
            logic [31:0] want;
            want = expected_distances.pop_front();
            if (rsp_distance !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("distance mismatch: expected %h actual %h", want, rsp_distance);
            end
         end
      end
   end

   task automatic add_pair(logic [15:0] a, logic [15:0] b, logic last_elem);
      pair_type p;
      p.elem_a = a;
      p.elem_b = b;
      p.last_elem = last_elem;
      pending_pairs.push_back(p);
   endtask

   task automatic drain;
      int waited;
      waited = 0;
      while ((pending_pairs.size() > 0 || req_valid || expected_distances.size() > 0)
             && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      // Pairs without a result may still be in the divider or root unit.
      repeat (200) @(posedge clock);
   endtask

   task automatic write_mode(logic [3:0] m);
      csr_write <= 1'b1;
      csr_mode <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      model_mode = m;
   endtask

   task automatic random_vectors(int count);
      int len;
      int n;
      n = 0;
      while (n < count) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            logic [15:0] a, b;
            case ($urandom_range(3))
               0: begin a = 16'($urandom); b = 16'($urandom); end
               1: begin a = 16'($urandom_range(15)); b = 16'($urandom_range(15)); end
               2: begin a = 16'($urandom); b = a; end
               default: begin
                  a = $urandom_range(1) ? 16'hffff : 16'h0;
                  b = 16'($urandom);
               end
            endcase
            add_pair(a, b, i == len - 1);
            n++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_elem_a = 0;
      req_elem_b = 0;
      req_last_elem = 0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_mode = 0;
      mismatch_count = 0;
      hold_cycles = 0;
      model_mode = vda_pkg::MODE_L2;
      model_acc = 0;
      send_idle_pct = 18;
      recv_idle_pct = 71;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes per mode, reset mode first.
      for (int m = 0; m < 16; m++) begin
         if (m != 0) write_mode(4'(m));
         add_pair(16'hffff, 16'h0000, 1'b0);
         add_pair(16'h0000, 16'h0000, 1'b0);
         add_pair(16'hffff, 16'hffff, 1'b1);
         if (m == vda_pkg::MODE_KCHI2) add_pair(16'h0001, 16'h0000, 1'b1);
         drain();
      end

      // Mode change in the middle of a vector keeps the partial sum.
      write_mode(vda_pkg::MODE_L1);
      add_pair(16'd100, 16'd3, 1'b0);
      drain();
      write_mode(vda_pkg::MODE_KL2);
      add_pair(16'hffff, 16'hffff, 1'b0);
      add_pair(16'hffff, 16'hfffe, 1'b1);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 18 : 0;
         for (int k = 0; k < 5; k++) begin
            write_mode(4'((k == 0) ? 0 : (k == 1) ? 10 : $urandom_range(15)));
            if (phase == 2 && k == 0) hold_cycles <= 300;
            random_vectors(60);
            drain();
         end
      end
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_distances.size() == 0) begin
         $display("vector_distance_accumulator_core_test: clean");
      end else begin
         $display("vector_distance_accumulator_core_test: errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("vector_distance_accumulator_core_test: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/vda_pkg.sv
design/vda_front.sv
design/vda_queue.sv
design/vda_back.sv
design/vector_distance_accumulator_core.sv
design/vda_checker.sv
verif/vector_distance_accumulator_core_test.sv
